// ===== rtl/saar_pkg.sv =====
`default_nettype none

package saar_pkg;

    // transaction field widths, fixed by the interface
    localparam int unsigned OP_W       = 2;
    localparam int unsigned FRAME_W    = 5;
    localparam int unsigned OWNER_W    = 16;
    localparam int unsigned PAGE_W     = 16;
    localparam int unsigned OUT_AGE_W  = 64;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 104;

    // operation codes
    localparam logic [OP_W-1:0] OP_TOUCH   = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT  = 2'd1;
    localparam logic [OP_W-1:0] OP_INSTALL = 2'd2;

    // touch count at which the set is aged before the touch
    localparam logic [1:0] TOUCH_WRAP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN_RD,
        ST_SCAN_EX,
        ST_FRAME_RD,
        ST_FRAME_EX,
        ST_INSTALL,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/saar_ram.sv =====
`default_nettype none

module saar_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_aging_replacement_unit.sv =====
`default_nettype none

// channel  | direction | tuser       | tdata (lowest bit up)
// s_ (op)  | in        | operation   | frame, owner_id, page
// m_ (res) | out       | -           | victim_frame, victim_free, frame_owner, frame_page,
//          |           |             | frame_age
//
// unused op and plain touch read their frame. a set holds up to W = FRAMES/SETS ways
// rounded up; a touch that ages its set walks it one way per cycle through the single frame
// ram read port; a select walks its set, ending early at a free way, after an ST_MOD step
// for page mod SETS when SETS is not a power of two. s_tready high when idle.
// synchronous active-low reset; frame entries read as zero until written (valid bits).
// a waiting result holds the block in its last state until m_tready takes it.

module set_assoc_aging_replacement_unit
    import saar_pkg::*;
#(
    parameter int unsigned FRAMES   = 32,
    parameter int unsigned SETS     = 8,
    parameter int unsigned AGE_BITS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // frame[4:0], owner_id[20:5], page[36:21]
    input  wire logic [OP_W-1:0]      s_tuser,  // operation[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // victim_frame[4:0], victim_free[5],
                                                // frame_owner[21:6], frame_page[37:22],
                                                // frame_age[101:38]
);

    localparam int unsigned FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned IW   = $clog2(FRAMES + SETS);
    localparam int unsigned MW   = OWNER_W + PAGE_W + AGE_BITS;
    localparam bit SETS_POW2     = ((SETS & (SETS - 1)) == 0);
    localparam int unsigned LUTN = 1 << FRAME_W;
    localparam int unsigned PAGE_HALF = PAGE_W / 2;
    localparam int unsigned MODN = 1 << PAGE_HALF;
    localparam logic [AGE_BITS-1:0] AGE_TOP = AGE_BITS'(1) << (AGE_BITS - 1);

    // frame number mod FRAMES and its set, for every value of the frame field
    logic [FW-1:0] frame_lut [LUTN];
    logic [SW-1:0] set_lut   [LUTN];

    for (genvar g = 0; g < LUTN; g++) begin : g_lut
        localparam int unsigned FM = g % FRAMES;
        assign frame_lut[g] = FW'(FM);
        assign set_lut[g]   = SW'(FM % SETS);
    end

    // residues of the low and high page bytes, summed for page mod SETS
    logic [SW-1:0] lo_mod_lut [MODN];
    logic [SW-1:0] hi_mod_lut [MODN];

    for (genvar g = 0; g < MODN; g++) begin : g_mod_lut
        assign lo_mod_lut[g] = SW'(g % SETS);
        assign hi_mod_lut[g] = SW'((g * MODN) % SETS);
    end

    state_t state_reg, state_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [FW-1:0]         frame_reg, frame_next;
    logic [OWNER_W-1:0]    owner_reg, owner_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic                  shift_reg, shift_next;
    logic [1:0]            phase_reg, phase_next;
    logic [SW-1:0]         set_reg, set_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [FW-1:0]         best_idx_reg, best_idx_next;
    logic                  best_free_reg, best_free_next;
    logic [OWNER_W-1:0]    best_owner_reg, best_owner_next;
    logic [PAGE_W-1:0]     best_page_reg, best_page_next;
    logic [AGE_BITS-1:0]   best_age_reg, best_age_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [FRAMES-1:0]     valid_reg, valid_next;
    logic                  rvalid_reg;

    logic                  ram_we;
    logic [FW-1:0]         ram_waddr;
    logic [MW-1:0]         ram_wdata;
    logic [FW-1:0]         ram_raddr;
    logic [MW-1:0]         ram_rdata;

    logic [OWNER_W-1:0]    rd_owner;
    logic [PAGE_W-1:0]     rd_page;
    logic [AGE_BITS-1:0]   rd_age;
    logic [IW-1:0]         way_next;
    logic                  way_more;
    logic                  s_fire;
    logic                  out_free;
    logic [SW:0]           mod_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // never-written frames read as zero
    assign rd_owner = rvalid_reg ? ram_rdata[OWNER_W-1:0] : '0;
    assign rd_page  = rvalid_reg ? ram_rdata[OWNER_W +: PAGE_W] : '0;
    assign rd_age   = rvalid_reg ? ram_rdata[OWNER_W+PAGE_W +: AGE_BITS] : '0;

    assign way_next = idx_reg + IW'(SETS);
    assign way_more = (way_next < IW'(FRAMES));

    assign mod_sum = {1'b0, lo_mod_lut[page_reg[PAGE_HALF-1:0]]}
                   + {1'b0, hi_mod_lut[page_reg[PAGE_W-1:PAGE_HALF]]};

    saar_ram #(
        .WIDTH (MW),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        OP_TOUCH:   state_next = (phase_reg == TOUCH_WRAP) ? ST_SCAN_RD
                                                                           : ST_FRAME_RD;
                        OP_SELECT:  state_next = SETS_POW2 ? ST_SCAN_RD : ST_MOD;
                        OP_INSTALL: state_next = ST_INSTALL;
                        default:    state_next = ST_FRAME_RD;
                    endcase
                end
            end
            ST_MOD:     state_next = ST_SCAN_RD;
            ST_SCAN_RD: begin
                // an empty set only happens when SETS exceeds FRAMES
                state_next = (IW'(set_reg) < IW'(FRAMES)) ? ST_SCAN_EX : ST_RESP;
            end
            ST_SCAN_EX: begin
                if (!shift_reg && rd_owner == '0) begin
                    state_next = ST_RESP;
                end else if (!way_more) begin
                    state_next = shift_reg ? ST_FRAME_RD : ST_RESP;
                end
            end
            ST_FRAME_RD: state_next = ST_FRAME_EX;
            ST_FRAME_EX: state_next = ST_RESP;
            ST_INSTALL:  state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        frame_next      = frame_reg;
        owner_next      = owner_reg;
        page_next       = page_reg;
        shift_next      = shift_reg;
        phase_next      = phase_reg;
        set_next        = set_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_free_next  = best_free_reg;
        best_owner_next = best_owner_reg;
        best_page_next  = best_page_reg;
        best_age_next   = best_age_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = frame_reg;
        ram_wdata       = {rd_age, rd_page, rd_owner};
        ram_raddr       = frame_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next         = s_tuser;
                    frame_next      = frame_lut[s_tdata[FRAME_W-1:0]];
                    owner_next      = s_tdata[FRAME_W +: OWNER_W];
                    page_next       = s_tdata[FRAME_W+OWNER_W +: PAGE_W];
                    shift_next      = 1'b0;
                    found_next      = 1'b0;
                    best_idx_next   = '0;
                    best_free_next  = 1'b0;
                    best_owner_next = '0;
                    best_page_next  = '0;
                    best_age_next   = '0;
                    case (s_tuser)
                        OP_TOUCH: begin
                            if (phase_reg == TOUCH_WRAP) begin
                                phase_next = '0;
                                shift_next = 1'b1;
                                set_next   = set_lut[s_tdata[FRAME_W-1:0]];
                            end else begin
                                phase_next = phase_reg + 2'd1;
                            end
                        end
                        OP_SELECT: begin
                            set_next = SETS_POW2
                                ? SW'(s_tdata[FRAME_W+OWNER_W +: PAGE_W] & PAGE_W'(SETS - 1))
                                : '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD: begin
                set_next = (mod_sum >= (SW + 1)'(SETS)) ? SW'(mod_sum - (SW + 1)'(SETS))
                                                        : mod_sum[SW-1:0];
            end
            ST_SCAN_RD: begin
                ram_raddr = FW'(set_reg);
                idx_next  = IW'(set_reg);
            end
            ST_SCAN_EX: begin
                if (shift_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[FW-1:0];
                    ram_wdata = {rd_age >> 1, rd_page, rd_owner};
                end else if (rd_owner == '0) begin
                    best_idx_next   = idx_reg[FW-1:0];
                    best_free_next  = 1'b1;
                    best_owner_next = rd_owner;
                    best_page_next  = rd_page;
                    best_age_next   = rd_age;
                end else if (!found_reg || rd_age < best_age_reg) begin
                    found_next      = 1'b1;
                    best_idx_next   = idx_reg[FW-1:0];
                    best_owner_next = rd_owner;
                    best_page_next  = rd_page;
                    best_age_next   = rd_age;
                end
                // fetch the next way while this one is handled
                ram_raddr = way_next[FW-1:0];
                idx_next  = way_next;
            end
            ST_FRAME_EX: begin
                best_owner_next = rd_owner;
                best_page_next  = rd_page;
                best_age_next   = rd_age;
                if (op_reg == OP_TOUCH) begin
                    ram_we        = 1'b1;
                    ram_wdata     = {rd_age | AGE_TOP, rd_page, rd_owner};
                    best_age_next = rd_age | AGE_TOP;
                end
            end
            ST_INSTALL: begin
                ram_we          = 1'b1;
                ram_wdata       = {AGE_BITS'(0), page_reg, owner_reg};
                best_owner_next = owner_reg;
                best_page_next  = page_reg;
                best_age_next   = '0;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, OUT_AGE_W'(best_age_reg), best_page_reg,
                                     best_owner_reg, best_free_reg, FRAME_W'(best_idx_reg)};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            rvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            rvalid_reg   <= valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        frame_reg      <= frame_next;
        owner_reg      <= owner_next;
        page_reg       <= page_next;
        shift_reg      <= shift_next;
        set_reg        <= set_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_free_reg  <= best_free_next;
        best_owner_reg <= best_owner_next;
        best_page_reg  <= best_page_next;
        best_age_reg   <= best_age_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

`default_nettype wire
